// File: rtl/segtree_pkg.sv
// Package for the segment tree range query block: widths, codes and the combining operator.
package segtree_pkg;

  localparam int DATA_W         = 64;
  localparam int LEAF_IDX_W     = 10;
  localparam int RANGE_W        = 11;
  localparam int LEAF_COUNT_DEF = 1024;

  localparam logic [DATA_W-1:0] MAX_IDENT = 64'h8000_0000_0000_0001;
  localparam logic [DATA_W-1:0] MIN_IDENT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] SUM_IDENT = '0;

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    MODE_MAX = 2'd0,
    MODE_MIN = 2'd1,
    MODE_SUM = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QWALK,
    ST_QDRAIN,
    ST_QDONE
  } state_e;

  function automatic logic [DATA_W-1:0] identity_of(mode_e mode);
    logic [DATA_W-1:0] id;
    unique case (mode)
      MODE_MAX: id = MAX_IDENT;
      MODE_MIN: id = MIN_IDENT;
      default:  id = SUM_IDENT;
    endcase
    return id;
  endfunction

  // Max and min return the first operand on a tie, so operand order never changes the bits.
  function automatic logic [DATA_W-1:0] combine(mode_e mode, logic [DATA_W-1:0] a,
                                                logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] res;
    unique case (mode)
      MODE_MAX: res = ($signed(a) < $signed(b)) ? b : a;
      MODE_MIN: res = ($signed(b) < $signed(a)) ? b : a;
      default:  res = a + b;
    endcase
    return res;
  endfunction

endpackage

// File: rtl/segment_tree_range_query.sv
// Segment tree with point update and range query over a synchronous node memory.
//
// The block keeps 2*LEAF_COUNT tree nodes of 64 bits in one on-chip memory with one write
// port and two registered read ports; leaf i lives at node LEAF_COUNT+i and node 1 is the
// root. A request is taken when start is high and busy is low, and busy stays high until
// the request is finished, so requests are handled one at a time. In a point update the
// leaf is written in the accept cycle together with a read of its sibling, and each
// following cycle combines the registered sibling with the running value, writes the
// parent and reads the parent's sibling, so the cost is one memory round trip per tree
// level. A range query walks the tree bottom-up with both read ports, one level per
// cycle; the last node pair then passes through the read registers, the pair register
// and the accumulator. The result appears on query_result_o for exactly one cycle with
// result_valid_o high, and the receiver cannot stall it; updates produce no result.
// After reset, and after every write of a legal combine mode, the block sweeps the whole
// memory to the new mode's identity, one node per cycle; busy is high during the sweep.
// Writes of the unused mode code are dropped and leave the tree untouched. Mode writes
// are meant to happen only while the block is idle.
module segment_tree_range_query #(
  parameter int LEAF_COUNT = segtree_pkg::LEAF_COUNT_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     combine_mode_we_i,
  input  logic        [1:0]                        combine_mode_i,
  input  logic                                     start,
  output logic                                     busy,
  input  logic                                     func_i,
  input  logic        [segtree_pkg::LEAF_IDX_W-1:0] leaf_index_i,
  input  logic signed [segtree_pkg::DATA_W-1:0]     write_value_i,
  input  logic        [segtree_pkg::RANGE_W-1:0]    range_lo_i,
  input  logic        [segtree_pkg::RANGE_W-1:0]    range_hi_i,
  output logic                                     result_valid_o,
  output logic signed [segtree_pkg::DATA_W-1:0]     query_result_o
);
  import segtree_pkg::*;

  // Node indexes need NODE_W bits; the query bounds can reach 2*LEAF_COUNT and need one more.
  localparam int LEVELS = $clog2(LEAF_COUNT);
  localparam int NODE_W = LEVELS + 1;
  localparam int PW     = NODE_W + 1;
  localparam int EW     = (RANGE_W > PW) ? RANGE_W : PW;
  localparam int DEPTH  = 2 * LEAF_COUNT;

  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(DEPTH - 1);
  localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
  localparam logic [EW-1:0]     N_EXT     = EW'(LEAF_COUNT);

  // Control state.
  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [NODE_W-1:0]   clr_q, clr_d;
  logic                s1_v_q, s1_v_d;
  logic                s1_sel_l_q, s1_sel_l_d;
  logic                s1_sel_r_q, s1_sel_r_d;
  logic                s2_v_q;

  // Datapath registers.
  logic [NODE_W-1:0]   node_q, node_d;
  logic [DATA_W-1:0]   cur_q, cur_d;
  logic [PW-1:0]       l_q, l_d;
  logic [PW-1:0]       r_q, r_d;
  logic [DATA_W-1:0]   acc_q, acc_d;
  logic [DATA_W-1:0]   pair_q, pair_d;

  // Node memory and its ports.
  logic [DATA_W-1:0]   tree_mem [DEPTH];
  logic [DATA_W-1:0]   rd_a_q, rd_b_q;
  logic                mem_we;
  logic [NODE_W-1:0]   mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic [NODE_W-1:0]   mem_raddr_a, mem_raddr_b;

  // Request decode.
  logic [EW-1:0]       lo_ext, hi_ext, hi_clamp;
  logic                q_empty;
  logic [PW-1:0]       q_l, q_r;
  logic                idx_ok;
  logic [NODE_W-1:0]   leaf_node;
  logic [NODE_W-1:0]   parent;
  logic [DATA_W-1:0]   upd_val;
  logic [DATA_W-1:0]   ident;
  logic                mode_wr_ok;

  assign ident      = identity_of(mode_q);
  assign mode_wr_ok = combine_mode_we_i && (combine_mode_i <= MODE_SUM);

  always_comb begin
    lo_ext    = EW'(range_lo_i);
    hi_ext    = EW'(range_hi_i);
    hi_clamp  = (hi_ext > N_EXT) ? N_EXT : hi_ext;
    q_empty   = (lo_ext >= hi_clamp);
    q_l       = q_empty ? '0 : PW'(lo_ext) + PW'(LEAF_COUNT);
    q_r       = q_empty ? '0 : PW'(hi_clamp) + PW'(LEAF_COUNT);
    idx_ok    = (EW'(leaf_index_i) < N_EXT);
    leaf_node = NODE_W'(LEAF_COUNT) + NODE_W'(leaf_index_i);
    parent    = node_q >> 1;
    upd_val   = combine(mode_q, cur_q, rd_a_q);
  end

  // Second query stage: fold the two nodes read at one level into a single value.
  always_comb begin
    pair_d = combine(mode_q, s1_sel_l_q ? rd_a_q : ident, s1_sel_r_q ? rd_b_q : ident);
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    clr_d       = clr_q;
    node_d      = node_q;
    cur_d       = cur_q;
    l_d         = l_q;
    r_d         = r_q;
    acc_d       = acc_q;
    s1_v_d      = 1'b0;
    s1_sel_l_d  = 1'b0;
    s1_sel_r_d  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = clr_q;
    mem_wdata   = ident;
    mem_raddr_a = node_q ^ ROOT_NODE;
    mem_raddr_b = NODE_W'(r_q);

    // Third query stage: merge the folded pair into the accumulator.
    if (s2_v_q) begin
      acc_d = combine(mode_q, acc_q, pair_q);
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = ident;
        clr_d     = clr_q + NODE_W'(1);
        if (clr_q == LAST_NODE) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (func_i == FUNC_QUERY) begin
            l_d     = q_l;
            r_d     = q_r;
            acc_d   = ident;
            state_d = ST_QWALK;
          end else if (idx_ok) begin
            // Write the leaf and fetch its sibling in the same cycle.
            mem_we      = 1'b1;
            mem_waddr   = leaf_node;
            mem_wdata   = write_value_i;
            mem_raddr_a = leaf_node ^ ROOT_NODE;
            node_d      = leaf_node;
            cur_d       = write_value_i;
            state_d     = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        // The parent and the parent's sibling are never the same node.
        mem_we      = 1'b1;
        mem_waddr   = parent;
        mem_wdata   = upd_val;
        mem_raddr_a = parent ^ ROOT_NODE;
        cur_d       = upd_val;
        node_d      = parent;
        if (parent == ROOT_NODE) begin
          state_d = ST_IDLE;
        end
      end
      ST_QWALK: begin
        if (l_q < r_q) begin
          mem_raddr_a = NODE_W'(l_q);
          mem_raddr_b = NODE_W'(r_q - PW'(1));
          s1_v_d      = 1'b1;
          s1_sel_l_d  = l_q[0];
          s1_sel_r_d  = r_q[0];
          l_d         = (l_q + PW'(l_q[0])) >> 1;
          r_d         = r_q >> 1;
        end else begin
          state_d = ST_QDRAIN;
        end
      end
      ST_QDRAIN: begin
        state_d = ST_QDONE;
      end
      ST_QDONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A legal mode write restarts the sweep under the new identity.
    if (mode_wr_ok) begin
      mode_d  = mode_e'(combine_mode_i);
      clr_d   = '0;
      state_d = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      mode_q     <= MODE_MAX;
      clr_q      <= '0;
      s1_v_q     <= 1'b0;
      s1_sel_l_q <= 1'b0;
      s1_sel_r_q <= 1'b0;
      s2_v_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      clr_q      <= clr_d;
      s1_v_q     <= s1_v_d;
      s1_sel_l_q <= s1_sel_l_d;
      s1_sel_r_q <= s1_sel_r_d;
      s2_v_q     <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    cur_q  <= cur_d;
    l_q    <= l_d;
    r_q    <= r_d;
    acc_q  <= acc_d;
    pair_q <= pair_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tree_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= tree_mem[mem_raddr_a];
    rd_b_q <= tree_mem[mem_raddr_b];
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_QDONE);
  assign query_result_o = acc_q;

  // The result strobe is a single-cycle pulse.
  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // The update walk never sits on the root or the unused node.
  a_upd_node : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> (node_q > ROOT_NODE))
    else $error("update walk reached an invalid node");

  // The query bounds never cross during the walk.
  a_walk_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QWALK) |-> (l_q <= r_q))
    else $error("query bounds crossed");

  // Folded pairs only arrive while the query has not yet delivered its result.
  a_pipe_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> ((state_q == ST_QWALK) || (state_q == ST_QDRAIN)))
    else $error("query pipeline not drained before result");

  // A legal mode write starts a sweep from node zero.
  a_mode_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_wr_ok |=> ((state_q == ST_CLEAR) && (clr_q == '0)))
    else $error("mode write did not restart the clearing sweep");

endmodule

// File: sim/segment_tree_range_query_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for segment_tree_range_query: directed table, then random phases.
module segment_tree_range_query_tb;
  import segtree_pkg::*;

  // The block is used at its default size. Every leaf index that the 10-bit port can carry
  // is therefore a real leaf. Only range ends can fall outside the tree.
  localparam int LEAVES = LEAF_COUNT_DEF;
  localparam int NODES = 2 * LEAVES;

  // This mode code is not legal. The block must drop a write of it and leave the tree alone.
  localparam logic [1:0] MODE_CODE_UNUSED = 2'd3;

  // The slowest correct run is about 1150 requests, plus one clearing sweep of the whole
  // tree per legal mode write. The limit leaves several times that.
  localparam int CYCLE_LIMIT = 400000;

  // An update produces no result. After the last answer arrives, the block may still be
  // walking up the tree, so this settling wait passes before the mode is touched or the run ends.
  localparam int SETTLE_CYCLES = 24;

  localparam int PHASES = 6;
  localparam int PHASE_REQUESTS = 185;
  localparam int DIRECTED_ROWS = 20;

  localparam logic [DATA_W-1:0] MOST_POSITIVE = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

  // One row of the directed table. Where `known` is set, `answer` is the result read
  // straight off the tree contents. Every other query row is checked against the tree model.
  typedef struct packed {
    logic                  func;
    logic [LEAF_IDX_W-1:0] leaf;
    logic [DATA_W-1:0]     value;
    logic [RANGE_W-1:0]    lo;
    logic [RANGE_W-1:0]    hi;
    logic                  known;
    logic [DATA_W-1:0]     answer;
  } stim_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         combine_mode_we_i = 1'b0;
  logic        [1:0]            combine_mode_i = MODE_MAX;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         func_i = FUNC_UPDATE;
  logic        [LEAF_IDX_W-1:0] leaf_index_i = '0;
  logic signed [DATA_W-1:0]     write_value_i = '0;
  logic        [RANGE_W-1:0]    range_lo_i = '0;
  logic        [RANGE_W-1:0]    range_hi_i = '0;
  logic                         result_valid_o;
  logic signed [DATA_W-1:0]     query_result_o;

  // The testbench keeps its own copy of the tree in heap order. Node 1 is the root, and
  // leaf i sits at node LEAVES+i. It also keeps its own copy of the combining mode.
  logic [DATA_W-1:0] shadow_nodes [1:NODES-1];
  mode_e             shadow_mode;

  // These are the answers still owed by the block, oldest first, one for each accepted query.
  logic [DATA_W-1:0] owed_answers [$];
  logic [DATA_W-1:0] oldest_answer;

  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned answers_checked = 0;
  int unsigned updates_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned mode_writes = 0;
  int unsigned hot_base = 0;

  segment_tree_range_query dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .combine_mode_we_i(combine_mode_we_i),
    .combine_mode_i   (combine_mode_i),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .leaf_index_i     (leaf_index_i),
    .write_value_i    (write_value_i),
    .range_lo_i       (range_lo_i),
    .range_hi_i       (range_hi_i),
    .result_valid_o   (result_valid_o),
    .query_result_o   (query_result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // This is the watchdog. A stuck handshake or an answer that never arrives ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tree model
  // ---------------------------------------------------------------------------------------

  // This value leaves an operand unchanged under the given mode, bar the most negative one
  // in max mode. An empty range answers with it, and a mode change fills the tree with it.
  function automatic logic [DATA_W-1:0] neutral_of(mode_e m);
    case (m)
      MODE_MAX: return MAX_IDENT;
      MODE_MIN: return MIN_IDENT;
      default:  return SUM_IDENT;
    endcase
  endfunction

  // Max and min keep the left operand on a tie. The sum wraps at 64 bits.
  function automatic logic [DATA_W-1:0] merge(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    logic signed [DATA_W-1:0] sa;
    logic signed [DATA_W-1:0] sb;
    sa = a;
    sb = b;
    case (shadow_mode)
      MODE_MAX: return (sa < sb) ? b : a;
      MODE_MIN: return (sb < sa) ? b : a;
      default:  return a + b;
    endcase
  endfunction

  task automatic clear_shadow();
    for (int n = 1; n < NODES; n++) shadow_nodes[n] = neutral_of(shadow_mode);
  endtask

  // Write one leaf, then rebuild every ancestor up to the root.
  task automatic shadow_update(input logic [LEAF_IDX_W-1:0] leaf, input logic [DATA_W-1:0] value);
    int node;
    node = LEAVES + int'(leaf);
    shadow_nodes[node] = value;
    while (node > 1) begin
      node = node >> 1;
      shadow_nodes[node] = merge(shadow_nodes[2 * node], shadow_nodes[2 * node + 1]);
    end
  endtask

  // Combine the leaves of [lo, hi) bottom-up. The walk adds nodes left to right from the
  // left edge and right to left from the right edge, and the accumulator is always the
  // left operand. A range end past the last leaf is cut back to LEAVES. A range with
  // nothing left after that answers with the neutral value.
  function automatic logic [DATA_W-1:0] range_answer(logic [RANGE_W-1:0] lo,
                                                     logic [RANGE_W-1:0] hi);
    int l;
    int r;
    logic [DATA_W-1:0] acc;
    acc = neutral_of(shadow_mode);
    l = int'(lo);
    r = (int'(hi) > LEAVES) ? LEAVES : int'(hi);
    if (l < r) begin
      l = l + LEAVES;
      r = r + LEAVES;
      while (l < r) begin
        if (l % 2 == 1) begin
          acc = merge(acc, shadow_nodes[l]);
          l = l + 1;
        end
        if (r % 2 == 1) begin
          r = r - 1;
          acc = merge(acc, shadow_nodes[r]);
        end
        l = l >> 1;
        r = r >> 1;
      end
    end
    return acc;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Answer checker
  // ---------------------------------------------------------------------------------------

  // A result is on the port for one cycle and cannot be held off, so it is taken at every
  // edge where the strobe is high. The sampled values are the ones from before that edge.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (owed_answers.size() == 0) begin
        $error("query_result: no query outstanding, got %h", query_result_o);
        fail_count++;
      end else begin
        oldest_answer = owed_answers.pop_front();
        answers_checked++;
        if (query_result_o !== oldest_answer) begin
          $error("query_result: expected %h, got %h", oldest_answer, query_result_o);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Request driving
  // ---------------------------------------------------------------------------------------

  // Put a request on the ports and hold it until the block takes it. A request is taken at
  // an edge where start is high and busy is low. At that edge the model is brought up to
  // date, and a query adds the answer it is owed. Start is left high here, so a request
  // that follows at once needs no new edge on it.
  task automatic send_request(input logic func, input logic [LEAF_IDX_W-1:0] leaf,
                              input logic [DATA_W-1:0] value, input logic [RANGE_W-1:0] lo,
                              input logic [RANGE_W-1:0] hi, input logic known,
                              input logic [DATA_W-1:0] answer);
    start         <= 1'b1;
    func_i        <= func;
    leaf_index_i  <= leaf;
    write_value_i <= value;
    range_lo_i    <= lo;
    range_hi_i    <= hi;
    do @(posedge clk_i); while (busy);
    if (func == FUNC_UPDATE) begin
      shadow_update(leaf, value);
      updates_sent++;
    end else begin
      owed_answers.push_back(known ? answer : range_answer(lo, hi));
      queries_sent++;
    end
  endtask

  // Sometimes the sender drops start right after a request is taken, so each gap begins
  // as the block starts its update or query walk.
  task automatic maybe_pause(input bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Bring the block to rest. First every owed answer must arrive. Then a trailing update
  // gets time to finish its walk, and busy must be low.
  task automatic drain();
    start <= 1'b0;
    while (owed_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // The mode is written only while the block is at rest. A legal code clears the tree to
  // the new neutral value. The block sweeps its memory while busy is high, and the next
  // request simply waits out that sweep. The unused code changes nothing.
  task automatic write_mode(input logic [1:0] code);
    drain();
    combine_mode_we_i <= 1'b1;
    combine_mode_i    <= code;
    @(posedge clk_i);
    combine_mode_we_i <= 1'b0;
    if (code <= MODE_SUM) begin
      shadow_mode = mode_e'(code);
      clear_shadow();
    end
    mode_writes++;
    repeat (4) @(posedge clk_i);
  endtask

  // Pick a write value. Extremes, values near zero and full 64-bit patterns all come up
  // often, so that the sums wrap and the signed compares meet both ends of the range.
  function automatic logic [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 6))
      0: v = MOST_POSITIVE;
      1: v = MOST_NEGATIVE;
      2: v = MAX_IDENT;
      3: begin
        v = DATA_W'($urandom_range(0, 200));
        v = v - 64'sd100;
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // Send one random request. Most updates land in a small hot window, and so do many
  // queries. This way the queries cover leaves that hold data and not only neutral values.
  // Some other queries take the edge shapes: the full tree, an end cut back past the last
  // leaf, an empty range, and a start beyond the leaves; the rest span a random range of
  // leaves. The fields that a request does not use carry random values.
  task automatic random_request();
    logic [LEAF_IDX_W-1:0] leaf;
    logic [RANGE_W-1:0]    lo;
    logic [RANGE_W-1:0]    hi;
    int unsigned           a;
    leaf = LEAF_IDX_W'($urandom);
    lo   = RANGE_W'($urandom);
    hi   = RANGE_W'($urandom);
    if ($urandom_range(0, 99) < 45) begin
      if ($urandom_range(0, 2) != 0) leaf = LEAF_IDX_W'(hot_base + $urandom_range(0, 15));
      send_request(FUNC_UPDATE, leaf, pick_value(), lo, hi, 1'b0, '0);
    end else begin
      case ($urandom_range(0, 9))
        0: begin
          lo = '0;
          hi = RANGE_W'($urandom_range(LEAVES, 2047));
        end
        1: begin
          a  = $urandom_range(0, LEAVES);
          lo = RANGE_W'(a);
          hi = RANGE_W'($urandom_range(0, a));
        end
        2: lo = RANGE_W'($urandom_range(LEAVES + 1, 2047));
        3, 4, 5: begin
          a  = hot_base + $urandom_range(0, 15);
          lo = RANGE_W'(a);
          hi = RANGE_W'(a + $urandom_range(1, 16));
        end
        default: begin
          a  = $urandom_range(0, LEAVES - 1);
          lo = RANGE_W'(a);
          hi = RANGE_W'($urandom_range(a + 1, LEAVES));
        end
      endcase
      send_request(FUNC_QUERY, leaf, {$urandom, $urandom}, lo, hi, 1'b0, '0);
    end
  endtask

  function automatic stim_row_t row(logic func, int leaf, logic [DATA_W-1:0] value, int lo,
                                    int hi, logic known, logic [DATA_W-1:0] answer);
    stim_row_t r;
    r.func   = func;
    r.leaf   = LEAF_IDX_W'(leaf);
    r.value  = value;
    r.lo     = RANGE_W'(lo);
    r.hi     = RANGE_W'(hi);
    r.known  = known;
    r.answer = answer;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------

  stim_row_t directed [DIRECTED_ROWS];
  mode_e     phase_modes [PHASES];

  initial begin
    // The tree starts out all neutral values in max mode. Each query below before the first
    // update therefore answers with the max neutral value, however its range is shaped.
    directed[0]  = row(FUNC_QUERY,  0,    '0,            0,    1024, 1'b1, MAX_IDENT);
    directed[1]  = row(FUNC_QUERY,  0,    '0,            5,    5,    1'b1, MAX_IDENT);
    directed[2]  = row(FUNC_QUERY,  0,    '0,            1024, 1024, 1'b1, MAX_IDENT);
    directed[3]  = row(FUNC_QUERY,  1023, ALL_ONES,      2047, 2047, 1'b1, MAX_IDENT);
    directed[4]  = row(FUNC_QUERY,  0,    '0,            100,  2047, 1'b1, MAX_IDENT);
    directed[5]  = row(FUNC_QUERY,  0,    '0,            700,  3,    1'b1, MAX_IDENT);
    // Updates at both ends of the leaf range carry the signed extremes. The range fields
    // hold values that the update must ignore.
    directed[6]  = row(FUNC_UPDATE, 0,    MOST_POSITIVE, 2047, 2047, 1'b0, '0);
    directed[7]  = row(FUNC_UPDATE, 1023, MOST_NEGATIVE, 2047, 0,    1'b0, '0);
    directed[8]  = row(FUNC_UPDATE, 512,  ALL_ONES,      0,    2047, 1'b0, '0);
    directed[9]  = row(FUNC_UPDATE, 1,    '0,            0,    0,    1'b0, '0);
    directed[10] = row(FUNC_UPDATE, 1022, 64'd1,         1024, 1024, 1'b0, '0);
    directed[11] = row(FUNC_QUERY,  0,    '0,            0,    1024, 1'b1, MOST_POSITIVE);
    // The most negative leaf loses to the neutral value, which is one above it.
    directed[12] = row(FUNC_QUERY,  0,    '0,            1023, 2047, 1'b1, MAX_IDENT);
    directed[13] = row(FUNC_QUERY,  0,    '0,            512,  513,  1'b1, ALL_ONES);
    directed[14] = row(FUNC_QUERY,  0,    '0,            1,    1023, 1'b0, '0);
    directed[15] = row(FUNC_QUERY,  0,    '0,            1022, 1024, 1'b0, '0);
    directed[16] = row(FUNC_QUERY,  1023, ALL_ONES,      0,    1,    1'b1, MOST_POSITIVE);
    directed[17] = row(FUNC_UPDATE, 0,    -64'sd5,       0,    0,    1'b0, '0);
    directed[18] = row(FUNC_QUERY,  0,    '0,            0,    2,    1'b0, '0);
    directed[19] = row(FUNC_QUERY,  0,    '0,            1,    2047, 1'b0, '0);

    // All three modes are visited twice, so that each mode takes over from each other mode.
    // The last phase runs with no gaps from the sender.
    phase_modes[0] = MODE_MIN;
    phase_modes[1] = MODE_SUM;
    phase_modes[2] = MODE_MAX;
    phase_modes[3] = MODE_SUM;
    phase_modes[4] = MODE_MIN;
    phase_modes[5] = MODE_MAX;

    shadow_mode = MODE_MAX;
    clear_shadow();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block sweeps its tree after reset, and the first request simply waits on busy.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_request(directed[i].func, directed[i].leaf, directed[i].value, directed[i].lo,
                   directed[i].hi, directed[i].known, directed[i].answer);
      maybe_pause(1'b1);
    end

    for (int p = 0; p < PHASES; p++) begin
      write_mode(phase_modes[p]);
      hot_base = $urandom_range(0, LEAVES - 16);
      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        // Halfway through the phase, the unused mode code is written. The tree must keep
        // its contents, so the queries that follow still see the leaves written before.
        if (k == PHASE_REQUESTS / 2) write_mode(MODE_CODE_UNUSED);
        random_request();
        // Every third stretch of 50 requests runs back to back.
        maybe_pause(p != PHASES - 1 && (k / 50) % 3 != 2);
      end
    end

    drain();

    $display("summary: %0d updates and %0d queries sent, %0d mode writes, %0d answers compared",
             updates_sent, queries_sent, mode_writes, answers_checked);
    $display("summary: max, min and wrapping sum modes, with empty, cut-back and full ranges");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/segtree_pkg.sv
rtl/segment_tree_range_query.sv
sim/segment_tree_range_query_tb.sv
